>>> hdl/signed_unsigned_divider_64_macros.svh
// ----------------------------------------------------------------------------
// signed_unsigned_divider_64 assertion macros
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SIGNED_UNSIGNED_DIVIDER_64_MACROS_SVH
`define SIGNED_UNSIGNED_DIVIDER_64_MACROS_SVH

// same-cycle implication
`define SUD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SUD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sud64_pkg.sv
// ----------------------------------------------------------------------------
// sud64_pkg
// Types and constants of the signed/unsigned 64-bit divider.
// ----------------------------------------------------------------------------
package sud64_pkg;

  localparam int FIELD_W       = 64;   // width of dividend, divisor and result fields
  localparam int REQ_W         = 2;
  localparam int DATA_WIDTH_DEF = 64;

  typedef logic [REQ_W-1:0] req_t;

  localparam req_t REQ_SQUO = 2'd0;
  localparam req_t REQ_SREM = 2'd1;
  localparam req_t REQ_UQUO = 2'd2;
  localparam req_t REQ_UREM = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NEG_A,
    ST_NEG_B,
    ST_DIV,
    ST_FIX
  } state_t;

  // operand select of the shared subtractor
  typedef enum logic [1:0] {
    SEL_NEG_A,
    SEL_NEG_B,
    SEL_STEP,
    SEL_NEG_RES
  } usel_t;

endpackage

>>> hdl/signed_unsigned_divider_64.sv
// Sequence: an accepted item passes ST_NEG_A, ST_NEG_B, the ST_DIV restoring steps and
//   ST_FIX before out_tvalid; a zero divisor goes from idle straight to ST_FIX.
// Occupancy: a new item is taken only in idle, after the last one leaves ST_FIX, as the
//   single subtractor does both operand negations, one restoring step per
//   cycle and the final sign fix-up; a result still held in the output stalls ST_FIX.
// Reset: synchronous active-low rst_n returns to idle with no result pending.
// ----------------------------------------------------------------------------
// signed_unsigned_divider_64
// Radix-2 restoring divider, signed or unsigned, quotient or remainder.
// ----------------------------------------------------------------------------
`include "signed_unsigned_divider_64_macros.svh"

module signed_unsigned_divider_64
  import sud64_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [2*FIELD_W-1:0] in_tdata,   // [63:0] dividend, [127:64] divisor
  input  logic [REQ_W-1:0]     in_tuser,   // [1:0] req_type

  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [FIELD_W-1:0]   out_tdata,  // [63:0] result
  output logic                 out_tuser   // [0] div_by_zero
);

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam int UW    = DATA_WIDTH + 2;

  state_t state_r, state_nxt;
  usel_t  usel;

  logic [DATA_WIDTH-1:0] a_r;      // dividend magnitude, becomes the quotient
  logic [DATA_WIDTH-1:0] b_r;      // divisor magnitude
  logic [DATA_WIDTH-1:0] rem_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  neg_a_r, neg_b_r, is_signed_r, want_rem_r, dbz_r;

  logic                  out_valid_r;
  logic [FIELD_W-1:0]    out_data_r;
  logic                  out_dbz_r;

  logic [UW-1:0]         unit_x, unit_y, unit_diff;
  logic [DATA_WIDTH-1:0] in_a, in_b, res_val;
  logic                  res_neg, step_ge;
  logic                  in_fire, out_fire, fix_go;
  req_t                  in_req;

  assign in_a     = in_tdata[DATA_WIDTH-1:0];
  assign in_b     = in_tdata[FIELD_W +: DATA_WIDTH];
  assign in_req   = in_tuser;
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_valid_r && out_tready;
  assign fix_go   = !out_valid_r || out_tready;

  // shared subtractor
  assign unit_diff = unit_x - unit_y;
  assign step_ge   = !unit_diff[UW-1];

  assign res_val = want_rem_r ? rem_r : a_r;
  assign res_neg = is_signed_r && (want_rem_r ? neg_a_r : (neg_a_r ^ neg_b_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_b == '0) ? ST_FIX : ST_NEG_A;
        end
      end
      ST_NEG_A: state_nxt = ST_NEG_B;
      ST_NEG_B: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        if (fix_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // subtractor operand control
  always_comb begin
    unique case (state_r)
      ST_NEG_A: usel = SEL_NEG_A;
      ST_NEG_B: usel = SEL_NEG_B;
      ST_DIV:   usel = SEL_STEP;
      default:  usel = SEL_NEG_RES;
    endcase
  end

  always_comb begin
    unique case (usel)
      SEL_NEG_A: begin
        unit_x = '0;
        unit_y = {2'b00, a_r};
      end
      SEL_NEG_B: begin
        unit_x = '0;
        unit_y = {2'b00, b_r};
      end
      SEL_STEP: begin
        // shifted partial remainder keeps its carry-out bit
        unit_x = {1'b0, rem_r, a_r[DATA_WIDTH-1]};
        unit_y = {2'b00, b_r};
      end
      default: begin
        unit_x = '0;
        unit_y = {2'b00, res_val};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FIX && fix_go) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          a_r         <= in_a;
          b_r         <= in_b;
          rem_r       <= '0;
          cnt_r       <= CNT_W'(DATA_WIDTH - 1);
          is_signed_r <= (in_req == REQ_SQUO) || (in_req == REQ_SREM);
          want_rem_r  <= (in_req == REQ_SREM) || (in_req == REQ_UREM);
          neg_a_r     <= ((in_req == REQ_SQUO) || (in_req == REQ_SREM)) &&
                         in_a[DATA_WIDTH-1];
          neg_b_r     <= ((in_req == REQ_SQUO) || (in_req == REQ_SREM)) &&
                         in_b[DATA_WIDTH-1];
          dbz_r       <= (in_b == '0);
        end
      end
      ST_NEG_A: begin
        if (neg_a_r) begin
          a_r <= unit_diff[DATA_WIDTH-1:0];
        end
      end
      ST_NEG_B: begin
        if (neg_b_r) begin
          b_r <= unit_diff[DATA_WIDTH-1:0];
        end
      end
      ST_DIV: begin
        rem_r <= step_ge ? unit_diff[DATA_WIDTH-1:0] : unit_x[DATA_WIDTH-1:0];
        a_r   <= {a_r[DATA_WIDTH-2:0], step_ge};
        cnt_r <= cnt_r - 1'b1;
      end
      ST_FIX: begin
        if (fix_go) begin
          out_dbz_r <= dbz_r;
          if (dbz_r) begin
            out_data_r <= '0;
          end else if (res_neg) begin
            out_data_r <= FIELD_W'(unit_diff[DATA_WIDTH-1:0]);
          end else begin
            out_data_r <= FIELD_W'(res_val);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_dbz_r;

  `SUD_ASSERT_NXT(a_accept_busy, in_fire, state_r != ST_IDLE, "accepted item did not start")
  `SUD_ASSERT_NXT(a_div_end, (state_r == ST_DIV) && (cnt_r == '0), state_r == ST_FIX,
                  "division steps overran")
  `SUD_ASSERT_IMP(a_dbz_zero, out_tvalid && out_tuser, out_tdata == '0,
                  "zero divisor result not zero")
  `SUD_ASSERT_IMP(a_hi_zero, out_tvalid, (out_tdata >> DATA_WIDTH) == '0,
                  "result bits above data width set")

endmodule
